/* src/modbus_discrete_input_slave_assert.svh */
// assertion macros used by the checker file
`ifndef MODBUS_DISCRETE_INPUT_SLAVE_ASSERT_SVH
`define MODBUS_DISCRETE_INPUT_SLAVE_ASSERT_SVH

// implication in the same cycle, off during reset
`define MDIS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mdis assertion failed");

// implication into the next cycle, off during reset
`define MDIS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mdis assertion failed");

// what must hold in the cycle after reset
`define MDIS_ASSERT_RST(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("mdis reset assertion failed");

`endif

/* src/mdis_pkg.sv */
// types, constants and crc function of the modbus discrete input slave
package mdis_pkg;

   localparam int MAX_FRAME_DEF = 128;
   localparam int HDR_BYTES     = 12;
   localparam int PDU_BYTES     = 6;
   localparam int TCP_ECHO      = 5;
   localparam int BODY_BYTES    = 5;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic OPC_BYTE = 1'b0;
   localparam logic OPC_GAP  = 1'b1;

   localparam logic [7:0] FC_READ_INPUTS = 8'h02;
   localparam logic [7:0] FC_READ_REGS   = 8'h04;
   localparam logic [7:0] START_MAX      = 8'h07;
   localparam logic [7:0] QTY_MAX        = 8'h08;
   localparam logic [7:0] QTY_ONE        = 8'h01;
   localparam logic [7:0] FC02_BYTES     = 8'h01;
   localparam logic [7:0] FC04_BYTES     = 8'h02;
   localparam logic [2:0] FC02_LEN       = 3'd4;
   localparam logic [2:0] FC04_LEN       = 3'd5;
   localparam logic [3:0] TCP_PREFIX     = 4'd6;
   localparam logic [3:0] CRC_BYTES      = 4'd2;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;

   typedef enum logic [7:0] {
      CSR_DEVICE_ADDRESS = 8'd0,
      CSR_TCP_FRAMING    = 8'd1
   } csr_index_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
      logic       rx_error;
      logic [7:0] pin_levels;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
   } rsp_type;

   typedef struct packed {
      logic                           tcp;
      logic [TCP_ECHO-1:0][7:0]       hdr;
      logic [2:0]                     len;
      logic [BODY_BYTES-1:0][7:0]     body;
   } reply_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* src/mdis_front.sv */
// front end: frame collection, crc check and request decode
module mdis_front #(
   parameter int MAX_FRAME = mdis_pkg::MAX_FRAME_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mdis_pkg::req_type   req_payload,
   input  logic [7:0]          device_address,
   input  logic                tcp_framing,
   output logic                push_valid,
   input  logic                push_ready,
   output mdis_pkg::reply_type push_data
);
   import mdis_pkg::*;

   logic [15:0]                 crc_ff, crc_in;
   logic [1:0][7:0]             dly_ff, dly_in;
   logic [7:0]                  count_ff, count_in;
   logic [HDR_BYTES-1:0][7:0]   hdr_ff, hdr_in;
   logic                        bad_ff, bad_in;

   logic                        accept;
   logic [PDU_BYTES-1:0][7:0]   pdu;
   logic [7:0]                  act;
   logic [8:0]                  mask;
   logic [7:0]                  data;
   logic                        crc_ok, base_ok, is02, is04;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      for (int k = 0; k < PDU_BYTES; k++) begin
         pdu[k] = tcp_framing ? hdr_ff[k + PDU_BYTES] : hdr_ff[k];
      end
      act     = ~req_payload.pin_levels;
      mask    = (9'd1 << pdu[5][3:0]) - 9'd1;
      data    = (act >> pdu[3][2:0]) & mask[7:0];
      crc_ok  = tcp_framing || (count_ff >= 8'd2 && dly_ff[0] == crc_ff[7:0]
                                && dly_ff[1] == crc_ff[15:8]);
      base_ok = !bad_ff && crc_ok && pdu[0] == device_address
                && pdu[2] == 8'h00 && pdu[4] == 8'h00;
      is02    = base_ok && pdu[1] == FC_READ_INPUTS && pdu[3] <= START_MAX
                && pdu[5] <= QTY_MAX;
      is04    = base_ok && pdu[1] == FC_READ_REGS && pdu[3] == 8'h00
                && pdu[5] == QTY_ONE;

      push_data.tcp = tcp_framing;
      for (int k = 0; k < TCP_ECHO; k++) begin
         push_data.hdr[k] = hdr_ff[k];
      end
      push_data.len     = is02 ? FC02_LEN : (is04 ? FC04_LEN : 3'd0);
      push_data.body[0] = device_address;
      push_data.body[1] = is02 ? FC_READ_INPUTS : FC_READ_REGS;
      push_data.body[2] = is02 ? FC02_BYTES : FC04_BYTES;
      push_data.body[3] = is02 ? data : 8'h00;
      push_data.body[4] = act;
      push_valid = accept && req_payload.opcode == OPC_GAP && (is02 || is04);
   end

   always_comb begin
      crc_in   = crc_ff;
      dly_in   = dly_ff;
      count_in = count_ff;
      hdr_in   = hdr_ff;
      bad_in   = bad_ff;
      if (accept) begin
         if (req_payload.opcode == OPC_GAP) begin
            crc_in   = CRC_INIT;
            dly_in   = '0;
            count_in = '0;
            hdr_in   = '0;
            bad_in   = 1'b0;
         end else begin
            if (req_payload.rx_error) begin
               bad_in = 1'b1;
            end
            if (count_ff < 8'(MAX_FRAME)) begin
               if (count_ff >= 8'd2) begin
                  crc_in = crc_byte(crc_ff, dly_ff[0]);
               end
               dly_in[0] = dly_ff[1];
               dly_in[1] = req_payload.rx_byte;
               if (count_ff < 8'(HDR_BYTES)) begin
                  hdr_in[count_ff[3:0]] = req_payload.rx_byte;
               end
               count_in = count_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_INIT;
         dly_ff   <= '0;
         count_ff <= '0;
         hdr_ff   <= '0;
         bad_ff   <= 1'b0;
      end else begin
         crc_ff   <= crc_in;
         dly_ff   <= dly_in;
         count_ff <= count_in;
         hdr_ff   <= hdr_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

/* src/mdis_queue.sv */
// reply queue between front end and transmit back end
module mdis_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  mdis_pkg::reply_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output mdis_pkg::reply_type pop_data
);
   import mdis_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   reply_type              entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]        wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign push_ready = cnt_ff != CntW'(QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = entry_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = do_push ? wr_ff + PtrW'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + PtrW'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* src/mdis_back.sv */
// back end: serializes replies and appends the rtu crc
module mdis_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  mdis_pkg::reply_type pop_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mdis_pkg::rsp_type   rsp_payload
);
   import mdis_pkg::*;

   logic        busy_ff, busy_in;
   reply_type   cur_ff, cur_in;
   logic [3:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic        valid_ff, valid_in;
   rsp_type     out_ff, out_in;

   logic        load, last;
   logic [3:0]  total, body_pos;
   logic [7:0]  tx;

   assign pop_ready   = !busy_ff;
   assign rsp_valid   = valid_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      total    = cur_ff.tcp ? {1'b0, cur_ff.len} + TCP_PREFIX
                            : {1'b0, cur_ff.len} + CRC_BYTES;
      last     = idx_ff == total - 4'd1;
      body_pos = cur_ff.tcp ? idx_ff - TCP_PREFIX : idx_ff;
      if (cur_ff.tcp) begin
         if (idx_ff < 4'(TCP_ECHO)) begin
            tx = cur_ff.hdr[idx_ff[2:0]];
         end else if (idx_ff == 4'(TCP_ECHO)) begin
            tx = {5'd0, cur_ff.len};
         end else begin
            tx = cur_ff.body[body_pos[2:0]];
         end
      end else begin
         if (idx_ff < {1'b0, cur_ff.len}) begin
            tx = cur_ff.body[body_pos[2:0]];
         end else if (idx_ff == {1'b0, cur_ff.len}) begin
            tx = crc_ff[7:0];
         end else begin
            tx = crc_ff[15:8];
         end
      end
      load = busy_ff && (!valid_ff || rsp_ready);

      busy_in  = busy_ff;
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      crc_in   = crc_ff;
      valid_in = valid_ff && !rsp_ready;
      out_in   = out_ff;
      if (pop_valid && pop_ready) begin
         busy_in = 1'b1;
         cur_in  = pop_data;
         idx_in  = '0;
         crc_in  = CRC_INIT;
      end
      if (load) begin
         valid_in       = 1'b1;
         out_in.tx_byte = tx;
         out_in.tx_last = last;
         idx_in         = idx_ff + 4'd1;
         if (!cur_ff.tcp && idx_ff < {1'b0, cur_ff.len}) begin
            crc_in = crc_byte(crc_ff, tx);
         end
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      crc_ff <= crc_in;
      out_ff <= out_in;
   end

endmodule

/* src/modbus_discrete_input_slave.sv */
// Modbus slave for eight discrete inputs, RTU or TCP framing. A request (a
// received byte or the gap that ends a frame) is taken every clock while the
// two-entry reply queue has room; the front end runs a one-byte crc update per byte.
// At a gap it checks the frame and queues a reply if the frame is valid; the
// back end registers each reply from the queue and sends it one byte per cycle
// while rsp_ready is high (6 or 7 bytes in RTU, 10 or 11 in TCP),
// computing the RTU crc as it goes. Configuration writes are always accepted.
module modbus_discrete_input_slave #(
   parameter int MAX_FRAME = mdis_pkg::MAX_FRAME_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mdis_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mdis_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [7:0]        csr_data
);
   import mdis_pkg::*;

   logic [7:0] dev_addr_ff, dev_addr_in;
   logic       tcp_ff, tcp_in;
   logic       push_valid, push_ready, pop_valid, pop_ready;
   reply_type  push_data, pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      dev_addr_in = dev_addr_ff;
      tcp_in      = tcp_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS: dev_addr_in = csr_data;
            CSR_TCP_FRAMING:    tcp_in      = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= '0;
         tcp_ff      <= 1'b0;
      end else begin
         dev_addr_ff <= dev_addr_in;
         tcp_ff      <= tcp_in;
      end
   end

   mdis_front #(
      .MAX_FRAME(MAX_FRAME)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .device_address (dev_addr_ff),
      .tcp_framing    (tcp_ff),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   mdis_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mdis_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* src/mdis_checker.sv */
// port checker for the modbus discrete input slave and its bind
`include "modbus_discrete_input_slave_assert.svh"

module mdis_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mdis_pkg::rsp_type rsp_payload
);
   import mdis_pkg::*;

   logic [3:0] cnt_ff, cnt_in;

   // bytes of the current response already taken
   always_comb begin
      cnt_in = cnt_ff;
      if (rsp_valid && rsp_ready) begin
         cnt_in = rsp_payload.tx_last ? 4'd0 : cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   `MDIS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_payload))
   `MDIS_ASSERT_IMP(a_rsp_last_len, clock, reset, rsp_valid && rsp_ready && rsp_payload.tx_last,
                    cnt_ff >= 4'd5 && cnt_ff <= 4'd10)
   `MDIS_ASSERT_IMP(a_rsp_max_len, clock, reset, rsp_valid && rsp_ready && !rsp_payload.tx_last,
                    cnt_ff < 4'd10)
   `MDIS_ASSERT_RST(a_reset_idle, clock, reset, !rsp_valid && req_ready)

endmodule

bind modbus_discrete_input_slave mdis_checker u_mdis_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
